FILE: rtl/dsdc_pkg.sv
// ----------------------------------------------------------------------------
// dsdc_pkg
// Shared types and constants of the daylight saving date check unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsdc_pkg;

  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned WDAY_W   = 3;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned NUM_STAGES = 9;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STANDARD    = 2'd0,
    ST_SAVING      = 2'd1,
    ST_BEFORE_RULE = 2'd2
  } status_e;

  localparam logic [YEAR_W-1:0]  RULE_FIRST_YEAR = 14'd2009;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Reciprocals for division by constants: x / n = (x * R) >> s over the value range used
  localparam logic [12:0] RECIP_100 = 13'd5243;   // s = 19, x < 16384
  localparam logic [14:0] RECIP_19  = 15'd27595;  // s = 19, x < 16384
  localparam logic [7:0]  RECIP_3   = 8'd171;     // s = 9,  x < 256
  localparam logic [10:0] RECIP_7W  = 11'd1171;   // s = 13, x < 1638
  localparam logic [11:0] RECIP_30  = 12'd2185;   // s = 16, x < 4096
  localparam logic [7:0]  RECIP_7N  = 8'd147;     // s = 10, x < 128

  typedef struct packed {
    logic [4:0] a;   // year mod 19
    logic [7:0] b;   // year / 100
    logic [6:0] c;   // year mod 100
    logic [7:0] j;   // (year - 1) / 100
    logic [6:0] k;   // (year - 1) mod 100
    logic       lp;  // leap year
  } yparts_t;

endpackage

`default_nettype wire

FILE: rtl/dsdc_req_if.sv
// ----------------------------------------------------------------------------
// dsdc_req_if
// Request channel: queried date and its weekday, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsdc_req_if
  import dsdc_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [WDAY_W-1:0]  weekday;

  modport source (
    output valid, day, month, year, weekday,
    input  ready
  );

  modport sink (
    input  valid, day, month, year, weekday,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/dsdc_rsp_if.sv
// ----------------------------------------------------------------------------
// dsdc_rsp_if
// Response channel: saving time status, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dsdc_rsp_if
  import dsdc_pkg::*;
();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, status,
    input  ready
  );

  modport sink (
    input  valid, status,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/dsdc_year_split.sv
// ----------------------------------------------------------------------------
// dsdc_year_split
// Stages 1-2: split the year into its century and remainder terms by
// reciprocal multiplication, and derive the leap year flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsdc_year_split
  import dsdc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire stage_en_t         en_i,
  input  wire logic [YEAR_W-1:0] year_i,
  output yparts_t                parts_o
);

  logic [YEAR_W-1:0] year_q, ym1_q;
  logic [26:0]       p100_d, p100_q;
  logic [26:0]       pm100_d, pm100_q;
  logic [28:0]       p19_d, p19_q;
  logic [YEAR_W-1:0] ym1_d;

  logic [7:0]        b, j;
  logic [9:0]        q19;
  logic [13:0]       c_w, a_w, k_w;
  yparts_t           parts_d, parts_q;

  assign ym1_d   = year_i - 14'd1;
  assign p100_d  = {13'd0, year_i} * {14'd0, RECIP_100};
  assign pm100_d = {13'd0, ym1_d} * {14'd0, RECIP_100};
  assign p19_d   = {15'd0, year_i} * {14'd0, RECIP_19};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      year_q  <= year_i;
      ym1_q   <= ym1_d;
      p100_q  <= p100_d;
      pm100_q <= pm100_d;
      p19_q   <= p19_d;
    end
  end

  assign b   = p100_q[26:19];
  assign j   = pm100_q[26:19];
  assign q19 = p19_q[28:19];
  assign c_w = year_q - ({6'd0, b} * 14'd100);
  assign k_w = ym1_q - ({6'd0, j} * 14'd100);
  assign a_w = year_q - ({4'd0, q19} * 14'd19);

  always_comb begin
    parts_d    = '0;
    parts_d.a  = a_w[4:0];
    parts_d.b  = b;
    parts_d.c  = c_w[6:0];
    parts_d.j  = j;
    parts_d.k  = k_w[6:0];
    parts_d.lp = (year_q[1:0] == 2'b00) && ((c_w[6:0] != 7'd0) || (b[1:0] == 2'b00));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      parts_q <= parts_d;
    end
  end

  assign parts_o = parts_q;

endmodule

`default_nettype wire

FILE: rtl/dsdc_zeller.sv
// ----------------------------------------------------------------------------
// dsdc_zeller
// Stages 3-4: weekday of the first of February by Zeller's congruence and
// the day of the third Sunday of February.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsdc_zeller
  import dsdc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire stage_en_t  en_i,
  input  wire yparts_t    parts_i,
  output logic [4:0]      end_day_o
);

  logic [10:0] zsum_d, zsum_q;
  logic [20:0] zp_d, zp_q;
  logic [7:0]  zq;
  logic [10:0] dw_w;
  logic [2:0]  dw;
  logic [4:0]  end_day_d, end_day_q;

  assign zsum_d = 11'd46 + {4'd0, parts_i.k} + {6'd0, parts_i.k[6:2]}
                + {5'd0, parts_i.j[7:2]} + ({3'd0, parts_i.j} * 11'd5);
  assign zp_d   = {10'd0, zsum_d} * {10'd0, RECIP_7W};

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      zsum_q <= zsum_d;
      zp_q   <= zp_d;
    end
  end

  assign zq        = zp_q[20:13];
  assign dw_w      = zsum_q - ({3'd0, zq} * 11'd7);
  assign dw        = dw_w[2:0];
  assign end_day_d = (dw == 3'd0) ? 5'd15 : (5'd22 - {2'd0, dw});

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      end_day_q <= end_day_d;
    end
  end

  assign end_day_o = end_day_q;

endmodule

`default_nettype wire

FILE: rtl/dsdc_easter.sv
// ----------------------------------------------------------------------------
// dsdc_easter
// Stages 3-8: Easter computus, ending in the combined month/day term of
// Easter Sunday; each reciprocal product is registered before its use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsdc_easter
  import dsdc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire stage_en_t  en_i,
  input  wire yparts_t    parts_i,
  output logic [7:0]      easter_t_o,
  output logic            lp_o
);

  // stage 3
  logic [2:0]  f;
  logic [7:0]  gx;
  logic [15:0] gp_d, gp_q3;
  logic [4:0]  a_q3, a_q4, a_q5, a_q6, a_q7;
  logic [7:0]  b_q3;
  logic [5:0]  d_q3;
  logic [1:0]  e_q3, e_q4, e_q5;
  logic [4:0]  i_q3, i_q4, i_q5;
  logic [1:0]  k_q3, k_q4, k_q5;
  logic        lp_q3, lp_q4, lp_q5, lp_q6, lp_q7, lp_q8;
  // stage 4
  logic [6:0]  g;
  logic [11:0] hsum_d, hsum_q4, hsum_q5;
  // stage 5
  logic [23:0] hp_d, hp_q5;
  // stage 6
  logic [6:0]  hq;
  logic [11:0] h_w;
  logic [4:0]  h_d, h_q6, h_q7;
  logic [6:0]  lsum_d, lsum_q6, lsum_q7;
  // stage 7
  logic [14:0] lp7_d, lp7_q7;
  // stage 8
  logic [4:0]  lq;
  logic [6:0]  l_w;
  logic [2:0]  l;
  logic [8:0]  msum;
  logic [7:0]  t_d, t_q8;

  assign f = 3'(parts_i.b >= 8'd17)  + 3'(parts_i.b >= 8'd42)  + 3'(parts_i.b >= 8'd67)
           + 3'(parts_i.b >= 8'd92)  + 3'(parts_i.b >= 8'd117) + 3'(parts_i.b >= 8'd142);
  assign gx   = parts_i.b - {5'd0, f} + 8'd1;
  assign gp_d = {8'd0, gx} * {8'd0, RECIP_3};

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      gp_q3 <= gp_d;
      a_q3  <= parts_i.a;
      b_q3  <= parts_i.b;
      d_q3  <= parts_i.b[7:2];
      e_q3  <= parts_i.b[1:0];
      i_q3  <= parts_i.c[6:2];
      k_q3  <= parts_i.c[1:0];
      lp_q3 <= parts_i.lp;
    end
  end

  assign g      = gp_q3[15:9];
  assign hsum_d = 12'd1935 + ({7'd0, a_q3} * 12'd19) + {4'd0, b_q3}
                - {6'd0, d_q3} - {5'd0, g};

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      hsum_q4 <= hsum_d;
      a_q4    <= a_q3;
      e_q4    <= e_q3;
      i_q4    <= i_q3;
      k_q4    <= k_q3;
      lp_q4   <= lp_q3;
    end
  end

  assign hp_d = {12'd0, hsum_q4} * {12'd0, RECIP_30};

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      hp_q5   <= hp_d;
      hsum_q5 <= hsum_q4;
      a_q5    <= a_q4;
      e_q5    <= e_q4;
      i_q5    <= i_q4;
      k_q5    <= k_q4;
      lp_q5   <= lp_q4;
    end
  end

  assign hq     = hp_q5[22:16];
  assign h_w    = hsum_q5 - ({5'd0, hq} * 12'd30);
  assign h_d    = h_w[4:0];
  assign lsum_d = 7'd67 + {4'd0, e_q5, 1'b0} + {1'b0, i_q5, 1'b0}
                - {2'd0, h_d} - {5'd0, k_q5};

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      h_q6    <= h_d;
      lsum_q6 <= lsum_d;
      a_q6    <= a_q5;
      lp_q6   <= lp_q5;
    end
  end

  assign lp7_d = {8'd0, lsum_q6} * {7'd0, RECIP_7N};

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      lp7_q7  <= lp7_d;
      lsum_q7 <= lsum_q6;
      h_q7    <= h_q6;
      a_q7    <= a_q6;
      lp_q7   <= lp_q6;
    end
  end

  assign lq   = lp7_q7[14:10];
  assign l_w  = lsum_q7 - ({2'd0, lq} * 7'd7);
  assign l    = l_w[2:0];
  assign msum = {4'd0, a_q7} + ({4'd0, h_q7} * 9'd11) + ({6'd0, l} * 9'd22);
  assign t_d  = 8'd114 + {3'd0, h_q7} + {5'd0, l} - ((msum >= 9'd451) ? 8'd7 : 8'd0);

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      t_q8  <= t_d;
      lp_q8 <= lp_q7;
    end
  end

  assign easter_t_o = t_q8;
  assign lp_o       = lp_q8;

endmodule

`default_nettype wire

FILE: rtl/daylight_saving_date_check_unit.sv
// ----------------------------------------------------------------------------
// daylight_saving_date_check_unit
// Brazilian daylight saving rule check for one date per request.
// ----------------------------------------------------------------------------
// Each request (day, month, year, weekday) yields one status: standard time,
// daylight saving, or year before 2009. The unit is a nine-stage pipeline
// that takes one request per cycle unless a response stall backs up to its
// input; the depth is set by the Easter computus, which registers each
// reciprocal multiplication before its quotient is used. Every stage
// has its own valid bit, so a stall on the response side holds the pipeline
// without loss and empty stages still fill. The unit keeps no state between
// requests; reset only empties the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module daylight_saving_date_check_unit
  import dsdc_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dsdc_req_if.sink    req_i,
  dsdc_rsp_if.source  rsp_o
);

  typedef struct packed {
    status_e          base;
    logic             feb_check;
    logic [DAY_W-1:0] day;
  } side_t;

  logic [NUM_STAGES-1:0] valid_q;
  stage_en_t             adv;

  side_t                 side_d;
  side_t                 side_q [NUM_STAGES-1];
  logic [4:0]            end_dly_q [4];

  yparts_t               parts;
  logic [4:0]            end_day;
  logic [7:0]            easter_t;
  logic                  lp;

  logic                  late;
  logic [7:0]            eday_w;
  logic [4:0]            eday;
  logic [5:0]            mar_sum;
  logic [4:0]            carn;
  logic [4:0]            end_fin;
  status_e               status_d, status_q;

  // stall chain: a stage advances when it is empty or its successor advances
  always_comb begin
    adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || rsp_o.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      adv[s] = !valid_q[s] || adv[s+1];
    end
  end

  assign req_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (adv[0]) begin
        valid_q[0] <= req_i.valid;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (adv[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  always_comb begin
    side_d           = '0;
    side_d.base      = ST_STANDARD;
    side_d.feb_check = 1'b0;
    side_d.day       = req_i.day;
    priority if (req_i.year < RULE_FIRST_YEAR) begin
      side_d.base = ST_BEFORE_RULE;
    end else if ((req_i.month == MONTH_NOV) || (req_i.month == MONTH_DEC)
                 || (req_i.month == MONTH_JAN)) begin
      side_d.base = ST_SAVING;
    end else if (req_i.month == MONTH_OCT) begin
      if (req_i.day >= 5'd21) begin
        side_d.base = ST_SAVING;
      end else if ((req_i.day >= 5'd15)
                   && ({1'b0, req_i.day} >= ({3'd0, req_i.weekday} + 6'd15))) begin
        side_d.base = ST_SAVING;
      end
    end else if (req_i.month == MONTH_FEB) begin
      if (req_i.day < 5'd15) begin
        side_d.base = ST_SAVING;
      end else begin
        side_d.feb_check = 1'b1;
      end
    end else begin
      side_d.base = ST_STANDARD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      side_q[0] <= side_d;
    end
    for (int s = 1; s < NUM_STAGES - 1; s++) begin
      if (adv[s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
    if (adv[4]) begin
      end_dly_q[0] <= end_day;
    end
    for (int s = 1; s < 4; s++) begin
      if (adv[s+4]) begin
        end_dly_q[s] <= end_dly_q[s-1];
      end
    end
  end

  dsdc_year_split u_year_split (
    .clk_i   (clk_i),
    .en_i    (adv),
    .year_i  (req_i.year),
    .parts_o (parts)
  );

  dsdc_zeller u_zeller (
    .clk_i     (clk_i),
    .en_i      (adv),
    .parts_i   (parts),
    .end_day_o (end_day)
  );

  dsdc_easter u_easter (
    .clk_i      (clk_i),
    .en_i       (adv),
    .parts_i    (parts),
    .easter_t_o (easter_t),
    .lp_o       (lp)
  );

  // carnival Sunday in February, zero when it falls in March
  assign late    = easter_t >= 8'd124;
  assign eday_w  = late ? (easter_t - 8'd123) : (easter_t - 8'd92);
  assign eday    = eday_w[4:0];
  assign mar_sum = {1'b0, eday} + {5'd0, lp};

  always_comb begin
    carn = 5'd0;
    if (late) begin
      if (eday < 5'd19) begin
        carn = eday + 5'd10 + {4'd0, lp};
      end
    end else if (mar_sum >= 6'd21) begin
      carn = 5'(mar_sum - 6'd21);
    end
  end

  assign end_fin = (carn == end_dly_q[3]) ? (end_dly_q[3] + 5'd7) : end_dly_q[3];

  always_comb begin
    status_d = side_q[NUM_STAGES-2].base;
    if (side_q[NUM_STAGES-2].feb_check) begin
      status_d = (side_q[NUM_STAGES-2].day >= end_fin) ? ST_STANDARD : ST_SAVING;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[NUM_STAGES-1]) begin
      status_q <= status_d;
    end
  end

  assign rsp_o.valid  = valid_q[NUM_STAGES-1];
  assign rsp_o.status = status_q;

endmodule

`default_nettype wire
